/* rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants and types of the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned TIMER_SLOTS = 32;

  localparam int unsigned ID_W   = 31;
  localparam int unsigned CB_W   = 16;
  localparam int unsigned TIME_W = 32;

  // input opcodes
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_PUMP  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SET_ANS    = 2'd0;
  localparam logic [1:0] KIND_CLEAR_DONE = 2'd1;
  localparam logic [1:0] KIND_FIRED      = 2'd2;
  localparam logic [1:0] KIND_PUMP_DONE  = 2'd3;

  // one entry of the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [CB_W-1:0]   callback;
    logic [TIME_W-1:0] due;
    logic [ID_W-1:0]   period;
  } slot_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] timer_id_res;
    logic [CB_W-1:0] callback_id_res;
    logic            last;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } out_req_t;

endpackage

/* rtl/stt_if.sv */
// ----------------------------------------------------------------------------
// stt_if
// Valid/ready channels of the software timer table: commands in, results out.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [15:0]         callback_id;
  logic signed [31:0]  delay_ms;
  logic                repeat_req;
  logic [30:0]         timer_id;
  logic [31:0]         now_ms;

  modport source (
    output valid, opcode, callback_id, delay_ms, repeat_req, timer_id, now_ms,
    input  ready
  );
  modport sink (
    input  valid, opcode, callback_id, delay_ms, repeat_req, timer_id, now_ms,
    output ready
  );
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [30:0] timer_id_res;
  logic [15:0] callback_id_res;
  logic        last;

  modport source (
    output valid, kind, timer_id_res, callback_id_res, last,
    input  ready
  );
  modport sink (
    input  valid, kind, timer_id_res, callback_id_res, last,
    output ready
  );
endinterface

/* rtl/software_timer_table.sv */
// ----------------------------------------------------------------------------
// software_timer_table
// Table of one-shot and periodic timers with set, clear and pump commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on in_i (valid/ready); results leave on out_o. Set answers
//   with one result holding the new id (0 when the table is full). Clear
//   answers with one done result. Pump emits one fired result per due slot in
//   slot order, then a done result; 'last' marks the final result of each
//   command. Opcode 3 is taken and gives no result.
// Sequencing:
//   One command is worked at a time; in_i.ready is high while the sequencer
//   is idle. Set walks the live bits one slot a cycle. Clear and pump stream
//   the slot memory one entry a cycle through its single read port, but a
//   pump pauses while a firing slot waits on the output register.
// Reset:
//   All slots are freed, the id counter and the recorded time go to 0.
//   Slot contents are not cleared; they are only used while live.
// Stall:
//   A result waits in the output register; a new command is still taken.
//   A pump that fires while the register is held pauses its scan.
// ----------------------------------------------------------------------------
module software_timer_table #(
  parameter int unsigned TIMER_SLOTS = stt_pkg::TIMER_SLOTS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);

  localparam int unsigned IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  logic              wr_en, rd_en, out_free, out_valid;
  logic [IdxW-1:0]   wr_addr, rd_addr;
  stt_pkg::slot_t    wr_data, rd_data;
  stt_pkg::out_req_t req;
  stt_pkg::res_t     res;

  stt_ctrl #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .IdxW        (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_free_i (out_free),
    .req_o      (req)
  );

  stt_slot_mem #(
    .Depth (TIMER_SLOTS),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  stt_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .free_o  (out_free),
    .valid_o (out_valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.valid           = out_valid;
  assign out_o.kind            = res.kind;
  assign out_o.timer_id_res    = res.timer_id_res;
  assign out_o.callback_id_res = res.callback_id_res;
  assign out_o.last            = res.last;

endmodule

/* rtl/stt_slot_mem.sv */
// ----------------------------------------------------------------------------
// stt_slot_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stt_slot_mem #(
  parameter int unsigned Depth = stt_pkg::TIMER_SLOTS,
  parameter int unsigned AddrW = 5
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  stt_pkg::slot_t    wr_data_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output stt_pkg::slot_t    rd_data_o
);

  stt_pkg::slot_t mem [Depth];
  stt_pkg::slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/stt_out_stage.sv */
// ----------------------------------------------------------------------------
// stt_out_stage
// Output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module stt_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stt_pkg::out_req_t req_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output stt_pkg::res_t     res_o
);

  logic          valid_q, valid_d;
  stt_pkg::res_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (req_i.push) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      res_q <= req_i.res;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // a held transaction must not be overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |-> !req_i.push)
    else $error("result overwritten while stalled");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && res_q == $past(res_q)))
    else $error("stalled result changed");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push |=> valid_q)
    else $error("pushed result not presented");

endmodule

/* rtl/stt_ctrl.sv */
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: live bits, id counter, time, and the per-slot scan over memory.
// ----------------------------------------------------------------------------
module stt_ctrl #(
  parameter int unsigned TIMER_SLOTS = stt_pkg::TIMER_SLOTS,
  parameter int unsigned IdxW        = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  stt_in_if.sink            in_i,
  output logic              wr_en_o,
  output logic [IdxW-1:0]   wr_addr_o,
  output stt_pkg::slot_t    wr_data_o,
  output logic              rd_en_o,
  output logic [IdxW-1:0]   rd_addr_o,
  input  stt_pkg::slot_t    rd_data_i,
  input  logic              out_free_i,
  output stt_pkg::out_req_t req_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_SLOTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SET  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [TIMER_SLOTS-1:0]      live_q, live_d;
  logic [stt_pkg::ID_W-1:0]    nid_q, nid_d;
  logic [stt_pkg::TIME_W-1:0]  time_q, time_d;

  // latched command
  logic [1:0]                  op_q;
  logic [stt_pkg::CB_W-1:0]    cb_q;
  logic [stt_pkg::TIME_W-1:0]  delay_q;
  logic                        rep_q;
  logic [stt_pkg::ID_W-1:0]    tid_q;

  logic                        accept;
  logic [stt_pkg::ID_W-1:0]    id_inc, id_new, period_new;
  logic                        hit_clr, fire, stall;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // ids skip zero, which is the table-full answer
  assign id_inc     = nid_q + stt_pkg::ID_W'(1);
  assign id_new     = (id_inc == '0) ? stt_pkg::ID_W'(1) : id_inc;
  assign period_new = !rep_q ? '0 :
                      (delay_q == '0) ? stt_pkg::ID_W'(1) : delay_q[stt_pkg::ID_W-1:0];

  assign hit_clr = live_q[idx_q] && (rd_data_i.ident == tid_q);
  assign fire    = live_q[idx_q] && (rd_data_i.due <= time_q);
  assign stall   = (op_q == stt_pkg::OP_PUMP) && fire && !out_free_i;

  // Writes go to the slot under evaluation and reads run ahead of it, so a
  // scan never reads an entry that is being written.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    live_d    = live_q;
    nid_d     = nid_q;
    time_d    = time_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q + IdxW'(1);
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q;
    wr_data_o = rd_data_i;
    req_o     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d = '0;
          case (in_i.opcode)
            stt_pkg::OP_SET: begin
              state_d = S_SET;
            end
            stt_pkg::OP_CLEAR: begin
              state_d   = S_SCAN;
              rd_en_o   = 1'b1;
              rd_addr_o = '0;
            end
            stt_pkg::OP_PUMP: begin
              state_d   = S_SCAN;
              rd_en_o   = 1'b1;
              rd_addr_o = '0;
              time_d    = in_i.now_ms;
            end
            default: begin
              // unused opcode: drop the transaction
            end
          endcase
        end
      end

      S_SET: begin
        if (!live_q[idx_q]) begin
          if (out_free_i) begin
            wr_en_o                = 1'b1;
            wr_data_o.ident        = id_new;
            wr_data_o.callback     = cb_q;
            wr_data_o.due          = time_q + delay_q;
            wr_data_o.period       = period_new;
            live_d[idx_q]          = 1'b1;
            nid_d                  = id_new;
            req_o.push             = 1'b1;
            req_o.res.kind         = stt_pkg::KIND_SET_ANS;
            req_o.res.timer_id_res = id_new;
            req_o.res.last         = 1'b1;
            state_d                = S_IDLE;
          end
        end else if (idx_q == LastIdx) begin
          if (out_free_i) begin
            req_o.push     = 1'b1;
            req_o.res.kind = stt_pkg::KIND_SET_ANS;
            req_o.res.last = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (op_q == stt_pkg::OP_PUMP) begin
            if (fire) begin
              req_o.push                = 1'b1;
              req_o.res.kind            = stt_pkg::KIND_FIRED;
              req_o.res.callback_id_res = rd_data_i.callback;
              if (rd_data_i.period != '0) begin
                wr_en_o       = 1'b1;
                wr_data_o.due = time_q + {1'b0, rd_data_i.period};
              end else begin
                live_d[idx_q] = 1'b0;
              end
            end
          end else if (hit_clr) begin
            live_d[idx_q] = 1'b0;
          end
          if (idx_q == LastIdx) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            rd_en_o = 1'b1;
          end
        end
      end

      S_DONE: begin
        if (out_free_i) begin
          req_o.push     = 1'b1;
          req_o.res.kind = (op_q == stt_pkg::OP_PUMP) ? stt_pkg::KIND_PUMP_DONE
                                                      : stt_pkg::KIND_CLEAR_DONE;
          req_o.res.last = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      live_q  <= '0;
      nid_q   <= '0;
      time_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      live_q  <= live_d;
      nid_q   <= nid_d;
      time_q  <= time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.opcode;
      cb_q    <= in_i.callback_id;
      delay_q <= in_i.delay_ms[31] ? '0 : in_i.delay_ms;
      rep_q   <= in_i.repeat_req;
      tid_q   <= in_i.timer_id;
    end
  end

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.push |-> out_free_i)
    else $error("result pushed into a full output stage");

  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == S_SET || state_q == S_SCAN))
    else $error("slot write outside a scan");

  a_set_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_o.push && req_o.res.kind == stt_pkg::KIND_SET_ANS &&
     req_o.res.timer_id_res != '0)
    |=> ($countones(live_q) == $countones($past(live_q)) + 1))
    else $error("successful set did not claim a slot");

  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && nid_d != nid_q) |-> (nid_d != '0))
    else $error("zero id assigned");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_o.push && req_o.res.last) |=> (state_q == S_IDLE))
    else $error("final result without return to idle");

endmodule

/* tb/software_timer_table_test.sv */
// ----------------------------------------------------------------------------
// software_timer_table_test
// Self-checking bench for the timer table: a directed pass over the delay and
// time extremes, clears and the unused opcode, a full-table pass, an output
// hold-off that backs up the command channel, and random timer traffic under
// three idle mixes. Each result is compared with a local model of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module software_timer_table_test;

  localparam int HOLD_CYCLES = 300;

  // opcode with no operation behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic [stt_pkg::CB_W-1:0]   callback_id;
    logic signed [31:0]         delay_ms;
    logic                       periodic;
    logic [stt_pkg::ID_W-1:0]   timer_id;
    logic [stt_pkg::TIME_W-1:0] now_ms;
  } timer_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  stt_in_if  cmd_ch ();
  stt_out_if res_ch ();

  software_timer_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // local copy of the timer table
  bit                         tt_live   [stt_pkg::TIMER_SLOTS];
  logic [stt_pkg::ID_W-1:0]   tt_ident  [stt_pkg::TIMER_SLOTS];
  logic [stt_pkg::CB_W-1:0]   tt_cb     [stt_pkg::TIMER_SLOTS];
  logic [stt_pkg::TIME_W-1:0] tt_due    [stt_pkg::TIMER_SLOTS];
  logic [stt_pkg::ID_W-1:0]   tt_period [stt_pkg::TIMER_SLOTS];
  logic [stt_pkg::ID_W-1:0]   id_counter;
  logic [stt_pkg::TIME_W-1:0] clock_ms;
  logic [stt_pkg::ID_W-1:0]   last_issued_id;

  stt_pkg::res_t pending_results[$];
  int   errors;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_req;
  int   hold_left;

  function automatic stt_pkg::res_t make_res(logic [1:0] kind,
                                             logic [stt_pkg::ID_W-1:0] id,
                                             logic [stt_pkg::CB_W-1:0] cb, logic last);
    stt_pkg::res_t r;
    r.kind            = kind;
    r.timer_id_res    = id;
    r.callback_id_res = cb;
    r.last            = last;
    return r;
  endfunction

  // update the table model and queue the results of one accepted command
  function automatic void apply_command(timer_cmd_t c);
    logic [stt_pkg::TIME_W-1:0] delay;
    logic [stt_pkg::ID_W-1:0]   id;
    bit                         placed;
    case (c.opcode)
      stt_pkg::OP_SET: begin
        delay  = c.delay_ms[31] ? '0 : c.delay_ms;
        placed = 1'b0;
        id     = '0;
        for (int i = 0; i < stt_pkg::TIMER_SLOTS && !placed; i++) begin
          if (!tt_live[i]) begin
            id = id_counter + stt_pkg::ID_W'(1);
            if (id == '0) id = stt_pkg::ID_W'(1);
            id_counter   = id;
            tt_live[i]   = 1'b1;
            tt_ident[i]  = id;
            tt_cb[i]     = c.callback_id;
            tt_due[i]    = clock_ms + delay;
            tt_period[i] = !c.periodic ? '0 :
                           (delay != '0 ? delay[stt_pkg::ID_W-1:0] : stt_pkg::ID_W'(1));
            placed       = 1'b1;
          end
        end
        last_issued_id = id;
        pending_results.push_back(make_res(stt_pkg::KIND_SET_ANS, id, '0, 1'b1));
      end
      stt_pkg::OP_CLEAR: begin
        for (int i = 0; i < stt_pkg::TIMER_SLOTS; i++)
          if (tt_live[i] && tt_ident[i] == c.timer_id) tt_live[i] = 1'b0;
        pending_results.push_back(make_res(stt_pkg::KIND_CLEAR_DONE, '0, '0, 1'b1));
      end
      stt_pkg::OP_PUMP: begin
        clock_ms = c.now_ms;
        for (int i = 0; i < stt_pkg::TIMER_SLOTS; i++) begin
          if (tt_live[i] && tt_due[i] <= c.now_ms) begin
            if (tt_period[i] != '0) tt_due[i] = c.now_ms + {1'b0, tt_period[i]};
            else tt_live[i] = 1'b0;
            pending_results.push_back(make_res(stt_pkg::KIND_FIRED, '0, tt_cb[i], 1'b0));
          end
        end
        pending_results.push_back(make_res(stt_pkg::KIND_PUMP_DONE, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  function automatic timer_cmd_t random_cmd(logic [1:0] opcode);
    timer_cmd_t c;
    c.opcode      = opcode;
    c.callback_id = stt_pkg::CB_W'($urandom());
    c.delay_ms    = $urandom();
    c.periodic    = 1'($urandom_range(1));
    c.timer_id    = stt_pkg::ID_W'($urandom());
    c.now_ms      = $urandom();
    return c;
  endfunction

  task automatic send_cmd(timer_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.opcode      <= c.opcode;
    cmd_ch.callback_id <= c.callback_id;
    cmd_ch.delay_ms    <= c.delay_ms;
    cmd_ch.repeat_req  <= c.periodic;
    cmd_ch.timer_id    <= c.timer_id;
    cmd_ch.now_ms      <= c.now_ms;
    do @(posedge clk_i); while (!cmd_ch.ready);
    apply_command(c);
  endtask

  task automatic send_set(logic [stt_pkg::CB_W-1:0] cb, logic [31:0] delay, logic periodic);
    timer_cmd_t c;
    c             = random_cmd(stt_pkg::OP_SET);
    c.callback_id = cb;
    c.delay_ms    = delay;
    c.periodic    = periodic;
    send_cmd(c);
  endtask

  task automatic send_clear(logic [stt_pkg::ID_W-1:0] id);
    timer_cmd_t c;
    c          = random_cmd(stt_pkg::OP_CLEAR);
    c.timer_id = id;
    send_cmd(c);
  endtask

  task automatic send_pump(logic [stt_pkg::TIME_W-1:0] now);
    timer_cmd_t c;
    c        = random_cmd(stt_pkg::OP_PUMP);
    c.now_ms = now;
    send_cmd(c);
  endtask

  task automatic clear_all_live();
    logic [stt_pkg::ID_W-1:0] ids[$];
    for (int i = 0; i < stt_pkg::TIMER_SLOTS; i++)
      if (tt_live[i]) ids.push_back(tt_ident[i]);
    foreach (ids[k]) send_clear(ids[k]);
  endtask

  task automatic test_directed();
    logic [stt_pkg::ID_W-1:0] short_id;
    send_set(16'h0000, 32'd0, 1'b0);
    send_set(16'hFFFF, 32'hFFFF_FFFF, 1'b1);   // negative delay, period floor of 1
    send_set(16'hA5A5, 32'h7FFF_FFFF, 1'b1);
    send_set(16'h5A5A, 32'h8000_0000, 1'b0);
    send_set(16'h1234, 32'd10, 1'b0);
    short_id = last_issued_id;
    send_clear(31'h7FFF_FFFF);                 // no such id
    send_clear('0);
    send_cmd(random_cmd(OP_UNUSED));           // no result
    send_pump(32'd0);
    send_clear(short_id);
    send_pump(32'hFFFF_FFFF);                  // reloads wrap past 2^32
    send_pump(32'd5);
    send_pump(32'hFFFF_FFF0);
    send_set(16'h00FF, 32'd100, 1'b1);         // due time wraps
    send_pump(32'h0000_0060);
    send_cmd(random_cmd(OP_UNUSED));
    clear_all_live();
  endtask

  task automatic test_full_table();
    clear_all_live();
    repeat (stt_pkg::TIMER_SLOTS + 2)
      send_set(stt_pkg::CB_W'($urandom()), $urandom_range(0, 500), 1'($urandom_range(1)));
    send_pump(clock_ms + 32'd1000);            // every slot fires
    clear_all_live();
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    repeat (6) begin
      send_set(stt_pkg::CB_W'($urandom()), $urandom_range(0, 20), 1'($urandom_range(1)));
      send_pump(clock_ms + $urandom_range(5, 30));
    end
  endtask

  task automatic test_random(int count);
    int n;
    int pick;
    int live_slots[$];
    logic [31:0] delay;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        case ($urandom_range(9))
          0, 1:    delay = 32'hFFFF_FFFF - $urandom_range(0, 999);
          2:       delay = $urandom();
          default: delay = $urandom_range(0, 200);
        endcase
        send_set(stt_pkg::CB_W'($urandom()), delay, 1'($urandom_range(1)));
      end else if (pick < 65) begin
        live_slots.delete();
        for (int i = 0; i < stt_pkg::TIMER_SLOTS; i++)
          if (tt_live[i]) live_slots.push_back(i);
        if (live_slots.size() > 0 && $urandom_range(9) < 7)
          send_clear(tt_ident[live_slots[$urandom_range(live_slots.size() - 1)]]);
        else
          send_clear(stt_pkg::ID_W'($urandom()));
      end else if (pick < 95) begin
        if ($urandom_range(9) == 0) send_pump($urandom());
        else send_pump(clock_ms + $urandom_range(0, 150));
      end else begin
        send_cmd(random_cmd(OP_UNUSED));
        n--;                                   // ignored commands do not count
      end
      n++;
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    hold_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    stt_pkg::res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $error("result with nothing expected: kind %0d", res_ch.kind);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.kind !== want.kind) begin
          errors++;
          $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
        end
        if (res_ch.timer_id_res !== want.timer_id_res) begin
          errors++;
          $error("timer_id_res: expected %0d, got %0d", want.timer_id_res,
                 res_ch.timer_id_res);
        end
        if (res_ch.callback_id_res !== want.callback_id_res) begin
          errors++;
          $error("callback_id_res: expected %0d, got %0d", want.callback_id_res,
                 res_ch.callback_id_res);
        end
        if (res_ch.last !== want.last) begin
          errors++;
          $error("last: expected %0d, got %0d", want.last, res_ch.last);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int guard;
    errors             = 0;
    hold_req           = 1'b0;
    tx_idle_pct        = 13;
    rx_idle_pct        = 82;
    id_counter         = '0;
    clock_ms           = '0;
    last_issued_id     = '0;
    for (int i = 0; i < stt_pkg::TIMER_SLOTS; i++) tt_live[i] = 1'b0;
    rst_ni             = 1'b0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.opcode      = stt_pkg::OP_SET;
    cmd_ch.callback_id = '0;
    cmd_ch.delay_ms    = '0;
    cmd_ch.repeat_req  = 1'b0;
    cmd_ch.timer_id    = '0;
    cmd_ch.now_ms      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_random(30);

    tx_idle_pct = 82;
    rx_idle_pct = 13;
    test_output_hold();
    test_random(30);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(20);

    cmd_ch.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() > 0 && guard < 200_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * stt_pkg::TIMER_SLOTS + 8) @(posedge clk_i);
    if (pending_results.size() > 0) begin
      errors++;
      $error("%0d expected results never arrived", pending_results.size());
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/stt_pkg.sv
rtl/stt_if.sv
rtl/stt_slot_mem.sv
rtl/stt_out_stage.sv
rtl/stt_ctrl.sv
rtl/software_timer_table.sv
tb/software_timer_table_test.sv
